// File: rtl/morse_dictionary_match_assert.svh
// assertion macros shared by the morse dictionary checker
`ifndef MORSE_DICTIONARY_MATCH_ASSERT_SVH
`define MORSE_DICTIONARY_MATCH_ASSERT_SVH

// condition that must hold in the same cycle
`define MDM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition that must hold in the next cycle
`define MDM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mdm_pkg.sv
// package: codes, types and the letter code table of the morse dictionary block
package mdm_pkg;

    localparam int MAX_SYMBOLS_DEF  = 64;
    localparam int DICT_ENTRIES_DEF = 16;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic KIND_SYMBOL = 1'b0;
    localparam logic KIND_ANSWER = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EMIT,
        ST_QCHK,
        ST_READ,
        ST_CMP,
        ST_ANSWER
    } mdm_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load_take;
        logic query_take;
        logic emit;
        logic scan_start;
        logic rd_issue;
        logic scan_next;
        logic answer;
    } mdm_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic slot_free;
        logic emit_end;
        logic q_over;
        logic dict_empty;
        logic hit;
        logic scan_last;
    } mdm_sts_t;

    typedef struct packed {
        logic       valid;
        logic [2:0] len;
        logic [3:0] bits;
    } mdm_code_t;

    // bit j of bits is symbol j, 1 = dash
    function automatic mdm_code_t mdm_code(input logic [4:0] letter);
        mdm_code_t c;
        c.valid = 1'b1;
        unique case (letter)
            5'd0:    begin c.bits = 4'd2;  c.len = 3'd2; end
            5'd1:    begin c.bits = 4'd1;  c.len = 3'd4; end
            5'd2:    begin c.bits = 4'd5;  c.len = 3'd4; end
            5'd3:    begin c.bits = 4'd1;  c.len = 3'd3; end
            5'd4:    begin c.bits = 4'd0;  c.len = 3'd1; end
            5'd5:    begin c.bits = 4'd4;  c.len = 3'd4; end
            5'd6:    begin c.bits = 4'd3;  c.len = 3'd3; end
            5'd7:    begin c.bits = 4'd0;  c.len = 3'd4; end
            5'd8:    begin c.bits = 4'd0;  c.len = 3'd2; end
            5'd9:    begin c.bits = 4'd14; c.len = 3'd4; end
            5'd10:   begin c.bits = 4'd5;  c.len = 3'd3; end
            5'd11:   begin c.bits = 4'd2;  c.len = 3'd4; end
            5'd12:   begin c.bits = 4'd3;  c.len = 3'd2; end
            5'd13:   begin c.bits = 4'd1;  c.len = 3'd2; end
            5'd14:   begin c.bits = 4'd7;  c.len = 3'd3; end
            5'd15:   begin c.bits = 4'd6;  c.len = 3'd4; end
            5'd16:   begin c.bits = 4'd11; c.len = 3'd4; end
            5'd17:   begin c.bits = 4'd2;  c.len = 3'd3; end
            5'd18:   begin c.bits = 4'd0;  c.len = 3'd3; end
            5'd19:   begin c.bits = 4'd1;  c.len = 3'd1; end
            5'd20:   begin c.bits = 4'd4;  c.len = 3'd3; end
            5'd21:   begin c.bits = 4'd8;  c.len = 3'd4; end
            5'd22:   begin c.bits = 4'd6;  c.len = 3'd3; end
            5'd23:   begin c.bits = 4'd9;  c.len = 3'd4; end
            5'd24:   begin c.bits = 4'd13; c.len = 3'd4; end
            5'd25:   begin c.bits = 4'd3;  c.len = 3'd4; end
            default: begin c.bits = 4'd0;  c.len = 3'd1; c.valid = 1'b0; end
        endcase
        return c;
    endfunction

endpackage

// File: rtl/mdm_in_if.sv
// input channel: letters and query symbols
interface mdm_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [4:0] letter;
    logic       symbol;
    logic       last;

    modport source (output valid, func, letter, symbol, last, input ready);
    modport sink   (input valid, func, letter, symbol, last, output ready);
endinterface

// File: rtl/mdm_out_if.sv
// output channel: encoded symbols and query answers
interface mdm_out_if;
    logic valid;
    logic ready;
    logic kind;
    logic code_symbol;
    logic end_of_run;
    logic found;
    logic overflow;

    modport source (output valid, kind, code_symbol, end_of_run, found, overflow,
                    input ready);
    modport sink   (input valid, kind, code_symbol, end_of_run, found, overflow,
                    output ready);
endinterface

// File: rtl/morse_dictionary_match.sv
// top level: morse encoder with dictionary store and query match
// load item: accepted in idle, then one encoded symbol per cycle (1 to 4) while the output slot is free
// query symbol not last: accepted, no result; last symbol: an answer after a scan of the entries,
// each entry costing one store read and one compare; the scan stops at a hit or the last entry
// one item is in work at a time; the output register frees the input side once loaded
// reset clears the dictionary count, word and query builders; no clearing pass is needed
module morse_dictionary_match
    import mdm_pkg::*;
#(
    parameter int MAX_SYMBOLS  = MAX_SYMBOLS_DEF,
    parameter int DICT_ENTRIES = DICT_ENTRIES_DEF
) (
    input logic           clk,
    input logic           rst_n,
    mdm_in_if.sink        item_ch,
    mdm_out_if.source     result_ch
);

    // controller and datapath talk only through these
    mdm_cmd_t cmd;
    mdm_sts_t sts;

    mdm_controller u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_ch.valid),
        .item_func  (item_ch.func),
        .item_last  (item_ch.last),
        .item_ready (item_ch.ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    // word builder, query builder, entry store and output register
    mdm_datapath #(
        .MAX_SYMBOLS  (MAX_SYMBOLS),
        .DICT_ENTRIES (DICT_ENTRIES)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .letter          (item_ch.letter),
        .symbol          (item_ch.symbol),
        .last            (item_ch.last),
        .out_ready       (result_ch.ready),
        .out_valid       (result_ch.valid),
        .out_kind        (result_ch.kind),
        .out_code_symbol (result_ch.code_symbol),
        .out_end_of_run  (result_ch.end_of_run),
        .out_found       (result_ch.found),
        .out_overflow    (result_ch.overflow)
    );

endmodule

// File: rtl/mdm_ram.sv
// generic single write port ram with registered read
module mdm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/mdm_datapath.sv
// datapath: code table, word and query builders, dictionary store, output register
module mdm_datapath
    import mdm_pkg::*;
#(
    parameter int MAX_SYMBOLS  = MAX_SYMBOLS_DEF,
    parameter int DICT_ENTRIES = DICT_ENTRIES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  mdm_cmd_t  cmd,
    output mdm_sts_t  sts,
    input  logic [4:0] letter,
    input  logic      symbol,
    input  logic      last,
    input  logic      out_ready,
    output logic      out_valid,
    output logic      out_kind,
    output logic      out_code_symbol,
    output logic      out_end_of_run,
    output logic      out_found,
    output logic      out_overflow
);

    localparam int LEN_W  = $clog2(MAX_SYMBOLS + 1);
    localparam int CNT_W  = $clog2(DICT_ENTRIES + 1);
    localparam int ADDR_W = (DICT_ENTRIES > 1) ? $clog2(DICT_ENTRIES) : 1;
    localparam int WORD_W = MAX_SYMBOLS + LEN_W;

    mdm_code_t              code;
    logic [3:0]             code_bits_reg, code_bits_next;
    logic [2:0]             code_len_reg, code_len_next;
    logic [1:0]             sym_idx_reg, sym_idx_next;
    logic                   word_last_reg, word_last_next;
    logic                   bad_reg, bad_next;
    logic [MAX_SYMBOLS-1:0] build_pat_reg, build_pat_next;
    logic [LEN_W-1:0]       build_len_reg, build_len_next;
    logic                   build_over_reg, build_over_next;
    logic                   drop_reg, drop_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [MAX_SYMBOLS-1:0] qry_pat_reg, qry_pat_next;
    logic [LEN_W-1:0]       qry_len_reg, qry_len_next;
    logic                   qry_over_reg, qry_over_next;
    logic [ADDR_W-1:0]      scan_idx_reg, scan_idx_next;
    logic                   found_reg, found_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_kind_reg, out_kind_next;
    logic                   out_sym_reg, out_sym_next;
    logic                   out_end_reg, out_end_next;
    logic                   out_found_reg, out_found_next;
    logic                   out_ovf_reg, out_ovf_next;

    logic                   cur_sym;
    logic                   sym_room;
    logic                   emit_end;
    logic                   dict_full;
    logic                   word_drop;
    logic                   store;
    logic                   q_room;
    logic [MAX_SYMBOLS-1:0] app_pat;
    logic [LEN_W-1:0]       app_len;
    logic [WORD_W-1:0]      rd_word;
    logic [MAX_SYMBOLS-1:0] rd_pat;
    logic [LEN_W-1:0]       rd_len;

    assign code      = mdm_code(letter);
    assign cur_sym   = code_bits_reg[sym_idx_reg];
    assign sym_room  = build_len_reg < LEN_W'(MAX_SYMBOLS);
    assign emit_end  = ({1'b0, sym_idx_reg} + 3'd1) == code_len_reg;
    assign dict_full = count_reg >= CNT_W'(DICT_ENTRIES);
    assign word_drop = drop_reg || bad_reg || build_over_reg || dict_full ||
                       (!sym_room && !bad_reg);
    assign store     = cmd.emit && emit_end && word_last_reg && !word_drop;
    assign q_room    = qry_len_reg < LEN_W'(MAX_SYMBOLS);
    // word with the current symbol appended
    assign app_pat   = build_pat_reg | (MAX_SYMBOLS'(cur_sym) << build_len_reg);
    assign app_len   = build_len_reg + LEN_W'(1);
    assign rd_pat    = rd_word[MAX_SYMBOLS-1:0];
    assign rd_len    = rd_word[WORD_W-1:MAX_SYMBOLS];

    always_comb
    begin
        code_bits_next  = code_bits_reg;
        code_len_next   = code_len_reg;
        sym_idx_next    = sym_idx_reg;
        word_last_next  = word_last_reg;
        bad_next        = bad_reg;
        build_pat_next  = build_pat_reg;
        build_len_next  = build_len_reg;
        build_over_next = build_over_reg;
        drop_next       = drop_reg;
        count_next      = count_reg;
        qry_pat_next    = qry_pat_reg;
        qry_len_next    = qry_len_reg;
        qry_over_next   = qry_over_reg;
        scan_idx_next   = scan_idx_reg;
        found_next      = found_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_kind_next   = out_kind_reg;
        out_sym_next    = out_sym_reg;
        out_end_next    = out_end_reg;
        out_found_next  = out_found_reg;
        out_ovf_next    = out_ovf_reg;

        if (cmd.load_take)
        begin
            code_bits_next = code.bits;
            code_len_next  = code.len;
            sym_idx_next   = 2'd0;
            word_last_next = last;
            bad_next       = !code.valid;
        end

        if (cmd.emit)
        begin
            // an invalid letter emits one dot flagged as overflow, appends nothing
            if (!bad_reg)
            begin
                if (sym_room)
                begin
                    build_pat_next = app_pat;
                    build_len_next = app_len;
                end
                else
                begin
                    build_over_next = 1'b1;
                end
            end
            else
            begin
                drop_next = 1'b1;
            end
            sym_idx_next   = sym_idx_reg + 2'd1;
            out_valid_next = 1'b1;
            out_kind_next  = KIND_SYMBOL;
            out_sym_next   = cur_sym;
            out_end_next   = emit_end;
            out_found_next = 1'b0;
            out_ovf_next   = bad_reg || (!sym_room && !bad_reg) ||
                             (emit_end && word_last_reg && (word_drop || bad_reg));
            if (store)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            // word ends: clear builder
            if (emit_end && word_last_reg)
            begin
                build_pat_next  = '0;
                build_len_next  = '0;
                build_over_next = 1'b0;
                drop_next       = 1'b0;
            end
        end

        if (cmd.query_take)
        begin
            if (q_room)
            begin
                qry_pat_next = qry_pat_reg | (MAX_SYMBOLS'(symbol) << qry_len_reg);
                qry_len_next = qry_len_reg + LEN_W'(1);
            end
            else
            begin
                qry_over_next = 1'b1;
            end
        end

        if (cmd.scan_start)
        begin
            scan_idx_next = '0;
            found_next    = 1'b0;
        end

        if (cmd.scan_next)
        begin
            scan_idx_next = scan_idx_reg + ADDR_W'(1);
            found_next    = sts.hit;
        end

        if (cmd.answer)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = KIND_ANSWER;
            out_sym_next   = 1'b0;
            out_end_next   = 1'b0;
            out_found_next = found_reg && !qry_over_reg;
            out_ovf_next   = qry_over_reg;
            qry_pat_next   = '0;
            qry_len_next   = '0;
            qry_over_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym_idx_reg    <= '0;
            word_last_reg  <= 1'b0;
            bad_reg        <= 1'b0;
            build_pat_reg  <= '0;
            build_len_reg  <= '0;
            build_over_reg <= 1'b0;
            drop_reg       <= 1'b0;
            count_reg      <= '0;
            qry_pat_reg    <= '0;
            qry_len_reg    <= '0;
            qry_over_reg   <= 1'b0;
            scan_idx_reg   <= '0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            sym_idx_reg    <= sym_idx_next;
            word_last_reg  <= word_last_next;
            bad_reg        <= bad_next;
            build_pat_reg  <= build_pat_next;
            build_len_reg  <= build_len_next;
            build_over_reg <= build_over_next;
            drop_reg       <= drop_next;
            count_reg      <= count_next;
            qry_pat_reg    <= qry_pat_next;
            qry_len_reg    <= qry_len_next;
            qry_over_reg   <= qry_over_next;
            scan_idx_reg   <= scan_idx_next;
            found_reg      <= found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_bits_reg <= code_bits_next;
        code_len_reg  <= code_len_next;
        out_kind_reg  <= out_kind_next;
        out_sym_reg   <= out_sym_next;
        out_end_reg   <= out_end_next;
        out_found_reg <= out_found_next;
        out_ovf_reg   <= out_ovf_next;
    end

    mdm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DICT_ENTRIES)
    ) u_store (
        .clk     (clk),
        .wr_en   (store),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data ({app_len, app_pat}),
        .rd_en   (cmd.rd_issue),
        .rd_addr (scan_idx_reg),
        .rd_data (rd_word)
    );

    always_comb
    begin
        sts.slot_free  = !out_valid_reg || out_ready;
        sts.emit_end   = emit_end;
        sts.q_over     = qry_over_reg;
        sts.dict_empty = count_reg == '0;
        sts.hit        = (rd_len == qry_len_reg) && (rd_pat == qry_pat_reg);
        sts.scan_last  = ({{(CNT_W-ADDR_W){1'b0}}, scan_idx_reg} + CNT_W'(1)) == count_reg;
    end

    assign out_valid       = out_valid_reg;
    assign out_kind        = out_kind_reg;
    assign out_code_symbol = out_sym_reg;
    assign out_end_of_run  = out_end_reg;
    assign out_found       = out_found_reg;
    assign out_overflow    = out_ovf_reg;

endmodule

// File: rtl/mdm_controller.sv
// controller: state machine sequencing letter emission and dictionary scan
module mdm_controller
    import mdm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    input  logic     item_func,
    input  logic     item_last,
    output logic     item_ready,
    input  mdm_sts_t sts,
    output mdm_cmd_t cmd
);

    mdm_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (item_func == FUNC_LOAD)
                    begin
                        state_next = ST_EMIT;
                    end
                    else if (item_last)
                    begin
                        state_next = ST_QCHK;
                    end
                end
            end
            ST_EMIT:
            begin
                if (sts.slot_free && sts.emit_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_QCHK:
            begin
                state_next = (sts.q_over || sts.dict_empty) ? ST_ANSWER : ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                state_next = (sts.hit || sts.scan_last) ? ST_ANSWER : ST_READ;
            end
            ST_ANSWER:
            begin
                if (sts.slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        item_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready     = 1'b1;
                cmd.load_take  = item_valid && (item_func == FUNC_LOAD);
                cmd.query_take = item_valid && (item_func == FUNC_QUERY);
            end
            ST_EMIT:
            begin
                cmd.emit = sts.slot_free;
            end
            ST_QCHK:
            begin
                cmd.scan_start = 1'b1;
            end
            ST_READ:
            begin
                cmd.rd_issue = 1'b1;
            end
            ST_CMP:
            begin
                cmd.scan_next = 1'b1;
            end
            ST_ANSWER:
            begin
                cmd.answer = sts.slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/mdm_checker.sv
// checker on the top level ports of the morse dictionary block, with its bind
`include "morse_dictionary_match_assert.svh"
module mdm_checker
    import mdm_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic in_func,
    input logic out_valid,
    input logic out_ready,
    input logic out_kind,
    input logic out_code_symbol,
    input logic out_end_of_run,
    input logic out_found,
    input logic out_overflow
);

    `MDM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_code_symbol) && $stable(out_end_of_run) && $stable(out_found) && $stable(out_overflow), "result item changed while stalled")
    `MDM_ASSERT_NOW(a_answer_clean, out_valid && out_kind == KIND_ANSWER, !out_code_symbol && !out_end_of_run, "answer item carries symbol fields")
    `MDM_ASSERT_NOW(a_symbol_nofound, out_valid && out_kind == KIND_SYMBOL, !out_found, "symbol item carries found")
    `MDM_ASSERT_NOW(a_ovf_nofound, out_valid && out_kind == KIND_ANSWER && out_overflow, !out_found, "overlong query reported found")
    `MDM_ASSERT_NEXT(a_load_busy, in_valid && in_ready && in_func == FUNC_LOAD, !in_ready, "item taken while a letter is still emitting")

endmodule

bind morse_dictionary_match mdm_checker u_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (item_ch.valid),
    .in_ready        (item_ch.ready),
    .in_func         (item_ch.func),
    .out_valid       (result_ch.valid),
    .out_ready       (result_ch.ready),
    .out_kind        (result_ch.kind),
    .out_code_symbol (result_ch.code_symbol),
    .out_end_of_run  (result_ch.end_of_run),
    .out_found       (result_ch.found),
    .out_overflow    (result_ch.overflow)
);

// File: tb/tb_morse_dictionary_match.sv
// testbench for morse_dictionary_match: directed table, random words and queries, scoreboard
module tb_morse_dictionary_match;
    import mdm_pkg::*;

    // one emitted item on the result channel, field by field
    typedef struct packed {
        logic kind;
        logic code_symbol;
        logic end_of_run;
        logic found;
        logic overflow;
    } morse_out_t;

    // one row of the directed table; want is used only when typed is set
    typedef struct packed {
        logic       func;
        logic [4:0] letter;
        logic       symbol;
        logic       last;
        logic       typed;
        morse_out_t want;
    } stim_row_t;

    localparam logic DOT  = 1'b0;
    localparam logic DASH = 1'b1;

    localparam int SYM_CAP     = MAX_SYMBOLS_DEF;
    localparam int DICT_CAP    = DICT_ENTRIES_DEF;
    localparam int OVER_LEN    = SYM_CAP + 1;
    localparam int QUERY_SPAN  = 72;

    localparam int RANDOM_ITEMS = 400;
    localparam int CALM_ITEMS   = 60;
    localparam int HOLD_CYCLES  = 150;
    localparam int TAIL_CYCLES  = 48;
    localparam int STALL_LIMIT  = 1000;

    localparam morse_out_t NO_RESULT = '0;

    // letter codes: bit j is symbol j, 1 = dash
    localparam logic [3:0] LETTER_DASHES [26] = '{
        4'd2, 4'd1, 4'd5, 4'd1, 4'd0, 4'd4, 4'd3, 4'd0, 4'd0, 4'd14, 4'd5, 4'd2, 4'd3,
        4'd1, 4'd7, 4'd6, 4'd11, 4'd2, 4'd0, 4'd1, 4'd4, 4'd8, 4'd6, 4'd9, 4'd13, 4'd3
    };
    localparam int LETTER_LEN [26] = '{
        2, 4, 4, 3, 1, 4, 3, 4, 2, 4, 3, 4, 2, 2, 3, 4, 4, 3, 3, 1, 3, 4, 3, 4, 4, 4
    };
    // letters with four symbols, used to build words that reach the symbol cap
    localparam int FOUR_SYM_LETTERS [12] = '{1, 2, 5, 7, 9, 11, 15, 16, 21, 23, 24, 25};

    // directed table
    localparam int DIRECTED_LEN = 21;
    localparam stim_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
        // query on an empty dictionary: no match
        '{FUNC_QUERY, 5'd0,  DASH, 1'b1, 1'b1, '{KIND_ANSWER, DOT, 1'b0, 1'b0, 1'b0}},
        // E is one dot, stored as a word of its own
        '{FUNC_LOAD,  5'd4,  DOT,  1'b1, 1'b1, '{KIND_SYMBOL, DOT, 1'b1, 1'b0, 1'b0}},
        '{FUNC_QUERY, 5'd31, DOT,  1'b1, 1'b0, NO_RESULT},
        // T is one dash, first letter of a two-letter word
        '{FUNC_LOAD,  5'd19, DOT,  1'b0, 1'b1, '{KIND_SYMBOL, DASH, 1'b1, 1'b0, 1'b0}},
        '{FUNC_LOAD,  5'd24, DASH, 1'b1, 1'b0, NO_RESULT},
        // invalid letter poisons the word, which is then dropped at A
        '{FUNC_LOAD,  5'd31, DASH, 1'b0, 1'b1, '{KIND_SYMBOL, DOT, 1'b1, 1'b0, 1'b1}},
        '{FUNC_LOAD,  5'd0,  DOT,  1'b1, 1'b0, NO_RESULT},
        // invalid letter that also ends its word
        '{FUNC_LOAD,  5'd26, DOT,  1'b1, 1'b1, '{KIND_SYMBOL, DOT, 1'b1, 1'b0, 1'b1}},
        '{FUNC_LOAD,  5'd25, DOT,  1'b1, 1'b0, NO_RESULT},
        // full code of the word T Y: hit
        '{FUNC_QUERY, 5'd0,  DASH, 1'b0, 1'b0, NO_RESULT},
        '{FUNC_QUERY, 5'd0,  DASH, 1'b0, 1'b0, NO_RESULT},
        '{FUNC_QUERY, 5'd0,  DOT,  1'b0, 1'b0, NO_RESULT},
        '{FUNC_QUERY, 5'd0,  DASH, 1'b0, 1'b0, NO_RESULT},
        '{FUNC_QUERY, 5'd0,  DASH, 1'b1, 1'b0, NO_RESULT},
        // prefix of stored codes, wrong length: miss
        '{FUNC_QUERY, 5'd0,  DASH, 1'b0, 1'b0, NO_RESULT},
        '{FUNC_QUERY, 5'd0,  DASH, 1'b1, 1'b0, NO_RESULT},
        // same length and same final symbol as Z, differs earlier: miss
        '{FUNC_QUERY, 5'd0,  DOT,  1'b0, 1'b0, NO_RESULT},
        '{FUNC_QUERY, 5'd0,  DASH, 1'b0, 1'b0, NO_RESULT},
        '{FUNC_QUERY, 5'd0,  DOT,  1'b0, 1'b0, NO_RESULT},
        '{FUNC_QUERY, 5'd0,  DOT,  1'b1, 1'b0, NO_RESULT},
        // B: dash then three dots
        '{FUNC_LOAD,  5'd1,  DASH, 1'b1, 1'b0, NO_RESULT}
    };

    logic clk = 1'b0;
    logic rst_n;

    mdm_in_if  item_ch ();
    mdm_out_if result_ch ();

    morse_dictionary_match uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_ch   (item_ch),
        .result_ch (result_ch)
    );

    always #4 clk = ~clk;

    // private copy of the dictionary, word builder and query builder
    logic [SYM_CAP-1:0] dict_pat [DICT_CAP];
    int                 dict_len [DICT_CAP];
    int                 dict_used = 0;
    logic [SYM_CAP-1:0] word_pat = '0;
    int                 word_len = 0;
    bit                 word_bad = 1'b0;
    logic [SYM_CAP-1:0] query_pat = '0;
    int                 query_len = 0;

    // symbols and answers still owed by the block, oldest first
    morse_out_t morse_out_due [$];

    int  mismatches     = 0;
    int  items_sent     = 0;
    int  symbols_seen   = 0;
    int  answers_seen   = 0;
    int  found_seen     = 0;
    int  overflows_seen = 0;
    int  words_stored   = 0;
    int  stall_cycles   = 0;

    // driver-side knobs; hold_req and calm_phase go to the receiver by nonblocking writes
    bit  gaps_allowed = 1'b1;
    bit  hold_req     = 1'b0;
    bit  calm_phase   = 1'b0;

    // append one symbol to a code; false once the code is past the cap
    function automatic bit push_symbol(inout logic [SYM_CAP-1:0] pat, inout int len,
                                       input logic s);
        if (len < SYM_CAP)
        begin
            if (s)
                pat[len] = 1'b1;
            len++;
            return 1'b1;
        end
        len = OVER_LEN;
        return 1'b0;
    endfunction

    // predicts what one accepted item emits and queues it; returns the count
    function automatic int encode_or_match(input logic f, input logic [4:0] letter,
                                           input logic s, input logic last);
        morse_out_t r;
        int         n;
        int         j;
        int         i;
        bit         ok;
        bit         hit;
        logic       sym;
        n = 0;
        if (f == FUNC_LOAD)
        begin
            if (letter < 26)
            begin
                for (j = 0; j < LETTER_LEN[letter]; j++)
                begin
                    sym = LETTER_DASHES[letter][j];
                    ok = push_symbol(word_pat, word_len, sym);
                    r.kind        = KIND_SYMBOL;
                    r.code_symbol = sym;
                    r.end_of_run  = (j == LETTER_LEN[letter] - 1);
                    r.found       = 1'b0;
                    r.overflow    = !ok;
                    morse_out_due.push_back(r);
                    n++;
                end
            end
            else
            begin
                // unknown letter: one flagged dot, word is poisoned
                word_bad = 1'b1;
                r = '{KIND_SYMBOL, DOT, 1'b1, 1'b0, 1'b1};
                morse_out_due.push_back(r);
                n = 1;
            end
            if (last)
            begin
                if (word_bad || word_len == OVER_LEN || dict_used >= DICT_CAP)
                begin
                    // dropped word: flag goes on the letter's final symbol
                    r = morse_out_due.pop_back();
                    r.overflow = 1'b1;
                    morse_out_due.push_back(r);
                end
                else
                begin
                    dict_pat[dict_used] = word_pat;
                    dict_len[dict_used] = word_len;
                    dict_used++;
                    words_stored++;
                end
                word_pat = '0;
                word_len = 0;
                word_bad = 1'b0;
            end
            return n;
        end
        void'(push_symbol(query_pat, query_len, s));
        if (!last)
            return 0;
        hit = 1'b0;
        if (query_len != OVER_LEN)
        begin
            for (i = 0; i < dict_used; i++)
            begin
                if (dict_len[i] == query_len && dict_pat[i] == query_pat)
                    hit = 1'b1;
            end
        end
        r = '{KIND_ANSWER, DOT, 1'b0, hit, (query_len == OVER_LEN)};
        morse_out_due.push_back(r);
        query_pat = '0;
        query_len = 0;
        return 1;
    endfunction

    // offer one item, maybe after a gap, and predict it once accepted
    task automatic offer_item(input logic f, input logic [4:0] l, input logic s,
                              input logic la, input logic typed, input morse_out_t want);
        int n;
        if (gaps_allowed && !calm_phase && $urandom_range(0, 4) == 0)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        item_ch.valid  <= 1'b1;
        item_ch.func   <= f;
        item_ch.letter <= l;
        item_ch.symbol <= s;
        item_ch.last   <= la;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        n = encode_or_match(f, l, s, la);
        // typed rows carry their own expectation in place of the predicted one
        if (typed && n != 0)
        begin
            void'(morse_out_due.pop_back());
            morse_out_due.push_back(want);
        end
        items_sent++;
    endtask

    task automatic send_load(input logic [4:0] l, input logic la);
        offer_item(FUNC_LOAD, l, 1'($urandom_range(0, 1)), la, 1'b0, NO_RESULT);
    endtask

    task automatic send_query(input logic s, input logic la);
        offer_item(FUNC_QUERY, 5'($urandom_range(0, 31)), s, la, 1'b0, NO_RESULT);
    endtask

    // one word of nletters letters; bad_pct percent of letters are invalid codes
    task automatic random_word(input int nletters, input bit four_only, input int bad_pct);
        int         k;
        logic [4:0] l;
        for (k = 0; k < nletters; k++)
        begin
            if ($urandom_range(0, 99) < bad_pct)
                l = 5'($urandom_range(26, 31));
            else if (four_only)
                l = 5'(FOUR_SYM_LETTERS[$urandom_range(0, 11)]);
            else
                l = 5'($urandom_range(0, 25));
            send_load(l, k == nletters - 1);
        end
    endtask

    // one query; forced_len > 0 gives random content of that length,
    // otherwise mostly a copy or near copy of a stored word
    task automatic random_query(input int forced_len);
        logic [QUERY_SPAN-1:0] pat;
        int                    len;
        int                    pick;
        int                    idx;
        int                    k;
        len = 0;
        pat = QUERY_SPAN'({$urandom, $urandom, $urandom});
        if (forced_len > 0)
        begin
            len = forced_len;
        end
        else if (dict_used > 0 && $urandom_range(0, 9) < 6)
        begin
            pick = $urandom_range(0, dict_used - 1);
            // long entries are copied only now and then, they cost many items
            if (dict_len[pick] <= 20 || $urandom_range(0, 7) == 0)
            begin
                len = dict_len[pick];
                pat = {{(QUERY_SPAN - SYM_CAP){1'b0}}, dict_pat[pick]};
                if ($urandom_range(0, 3) == 0)
                begin
                    // near miss: one symbol flipped
                    idx = $urandom_range(0, len - 1);
                    pat[idx] = ~pat[idx];
                end
                else if ($urandom_range(0, 5) == 0)
                begin
                    // near miss: one symbol too many
                    pat[len] = 1'($urandom_range(0, 1));
                    len++;
                end
            end
        end
        if (len == 0)
            len = $urandom_range(1, 12);
        for (k = 0; k < len; k++)
            send_query(pat[k], k == len - 1);
    endtask

    // wait until every owed result has come out
    task automatic wait_for_drain();
        @(posedge clk);
        while (morse_out_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic void check_field(input string name, input logic want, input logic got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // scoreboard: every accepted result against the oldest expectation
    always @(posedge clk)
    begin : check_results
        morse_out_t got;
        morse_out_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.kind        = result_ch.kind;
            got.code_symbol = result_ch.code_symbol;
            got.end_of_run  = result_ch.end_of_run;
            got.found       = result_ch.found;
            got.overflow    = result_ch.overflow;
            if (got.kind == KIND_ANSWER)
            begin
                answers_seen++;
                if (got.found)
                    found_seen++;
            end
            else
            begin
                symbols_seen++;
            end
            if (got.overflow)
                overflows_seen++;
            if (morse_out_due.size() == 0)
            begin
                $display("%0t: result with nothing due, expected none, actual %b",
                         $time, got);
                mismatches++;
            end
            else
            begin
                want = morse_out_due.pop_front();
                check_field("kind", want.kind, got.kind);
                check_field("code_symbol", want.code_symbol, got.code_symbol);
                check_field("end_of_run", want.end_of_run, got.end_of_run);
                check_field("found", want.found, got.found);
                check_field("overflow", want.overflow, got.overflow);
            end
        end
    end

    // watchdog: too long with no handshake on either channel ends the run
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            begin
                stall_cycles <= 0;
            end
            else if (stall_cycles + 1 >= STALL_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles, %0d results still due",
                         $time, STALL_LIMIT, morse_out_due.size());
                $display("morse_dictionary_match regression: fail");
                $finish;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // receiver: random ready bursts, one long hold-off on request, steady at the end
    initial
    begin : receiver
        int  n;
        int  pick;
        bit  held;
        held = 1'b0;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req && !held)
            begin
                // long hold-off so the block fills up and stalls its input
                held = 1'b1;
                result_ch.ready <= 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++)
                    @(posedge clk);
            end
            else if (calm_phase)
            begin
                result_ch.ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                pick = $urandom_range(0, 9);
                if (pick < 3)
                begin
                    result_ch.ready <= 1'b0;
                    repeat ($urandom_range(1, 9)) @(posedge clk);
                end
                else if (pick == 9)
                begin
                    // stretch with no stall at all
                    result_ch.ready <= 1'b1;
                    repeat (40) @(posedge clk);
                end
                else
                begin
                    result_ch.ready <= 1'b1;
                    repeat ($urandom_range(1, 16)) @(posedge clk);
                end
            end
        end
    end

    // sender: reset, directed table, random episodes, drain and verdict
    initial
    begin : sender
        int  k;
        int  pick;
        int  big_words;
        int  long_queries;
        int  no_gap_until;
        bit  hold_done;
        bit  drain_done;
        big_words    = 0;
        long_queries = 0;
        no_gap_until = 0;
        hold_done    = 1'b0;
        drain_done   = 1'b0;

        rst_n          <= 1'b0;
        item_ch.valid  <= 1'b0;
        item_ch.func   <= FUNC_LOAD;
        item_ch.letter <= 5'd0;
        item_ch.symbol <= DOT;
        item_ch.last   <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table first
        for (k = 0; k < DIRECTED_LEN; k++)
        begin
            offer_item(DIRECTED_ROWS[k].func, DIRECTED_ROWS[k].letter,
                       DIRECTED_ROWS[k].symbol, DIRECTED_ROWS[k].last,
                       DIRECTED_ROWS[k].typed, DIRECTED_ROWS[k].want);
        end

        // random episodes: mostly well-formed words and queries, some noise
        while (items_sent < DIRECTED_LEN + RANDOM_ITEMS)
        begin
            if (!hold_done && items_sent >= DIRECTED_LEN + 160)
            begin
                // receiver stalls while items keep coming back to back
                hold_done = 1'b1;
                hold_req <= 1'b1;
                no_gap_until = items_sent + 30;
            end
            if (!drain_done && items_sent >= DIRECTED_LEN + 260)
            begin
                // sender pauses until nothing is owed
                drain_done = 1'b1;
                item_ch.valid <= 1'b0;
                wait_for_drain();
            end
            if (items_sent >= DIRECTED_LEN + RANDOM_ITEMS - CALM_ITEMS)
                calm_phase <= 1'b1;
            gaps_allowed = (items_sent >= no_gap_until) && ($urandom_range(0, 3) != 0);

            pick = $urandom_range(0, 99);
            if (pick < 3 && big_words < 3)
            begin
                // first one is exactly at the symbol cap, later ones pass it
                random_word((big_words == 0) ? 16 : 17 + int'($urandom_range(0, 1)),
                            1'b1, 0);
                big_words++;
            end
            else if (pick < 6 && long_queries < 3)
            begin
                random_query((long_queries == 0) ? SYM_CAP : int'($urandom_range(65, 70)));
                long_queries++;
            end
            else if (pick < 10)
            begin
                // noise: fully random fields
                repeat ($urandom_range(1, 3))
                    offer_item(1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                               1'b0, NO_RESULT);
            end
            else if (pick < 16)
            begin
                // broken query: a word lands in the middle of it
                repeat ($urandom_range(1, 3))
                    send_query(1'($urandom_range(0, 1)), 1'b0);
                random_word($urandom_range(1, 2), 1'b0, 4);
                random_query(0);
            end
            else if (pick < 42)
            begin
                random_word($urandom_range(1, 3), 1'b0, 4);
            end
            else
            begin
                random_query(0);
            end
        end

        item_ch.valid <= 1'b0;
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (morse_out_due.size() != 0)
        begin
            $display("%0t: %0d results never came, expected none left, actual %0d",
                     $time, morse_out_due.size(), morse_out_due.size());
            mismatches++;
        end

        $display("covered %0d items: %0d encoded symbols and %0d query answers checked",
                 items_sent, symbols_seen, answers_seen);
        $display("%0d words stored of %0d slots, %0d answers matched, %0d overflow results",
                 words_stored, DICT_CAP, found_seen, overflows_seen);
        if (mismatches == 0)
            $display("morse_dictionary_match regression: pass");
        else
            $display("morse_dictionary_match regression: fail");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/mdm_pkg.sv
rtl/mdm_in_if.sv
rtl/mdm_out_if.sv
rtl/mdm_ram.sv
rtl/mdm_datapath.sv
rtl/mdm_controller.sv
rtl/morse_dictionary_match.sv
rtl/mdm_checker.sv
tb/tb_morse_dictionary_match.sv
